[hw/rtl/bzp_pkg.sv]
// shared constants and types for the cubic bezier point and perpendicular block
`timescale 1ns / 1ps
package bzp_pkg;

    localparam int DEF_COORD_WIDTH = 16;
    localparam int DEF_T_FRAC_BITS = 15;
    localparam int DEF_D_WIDTH     = DEF_COORD_WIDTH + DEF_T_FRAC_BITS + 7;

    localparam int CFG_W = 48;
    localparam int IDX_W = 3;

    localparam logic [IDX_W-1:0] REG_START_POINT    = 3'd0;
    localparam logic [IDX_W-1:0] REG_END_POINT      = 3'd1;
    localparam logic [IDX_W-1:0] REG_START_CONTROL  = 3'd2;
    localparam logic [IDX_W-1:0] REG_END_CONTROL    = 3'd3;
    localparam logic [IDX_W-1:0] REG_SURFACE_NORMAL = 3'd4;

    localparam int NRM_W      = 16;
    localparam int NRM_FRAC   = 14;
    localparam int UN_W       = 16;
    localparam int MAG_W      = 64;
    localparam int NORM_STEPS = 6;
    localparam int UNIT_BITS  = 30;
    localparam int DN_W       = UNIT_BITS + 2;
    localparam int SQ_W       = 2 * UNIT_BITS + 2;
    localparam int ROOT_W     = UNIT_BITS + 1;
    localparam int Q_W        = 16;
    localparam int REM_W      = ROOT_W + Q_W;

    localparam int BASIS_LAT = 6;
    localparam int LANE_LAT  = 4;
    localparam int UNIT_LAT  = NORM_STEPS + ROOT_W + Q_W + 6;

    typedef struct packed {
        logic valid;
        logic zero;
    } ctl_t;

endpackage

[hw/rtl/bzp_basis.sv]
// bernstein basis weights and tangent coefficients from the curve parameter
`timescale 1ns / 1ps
module bzp_basis
#(
    parameter int T_FRAC_BITS = bzp_pkg::DEF_T_FRAC_BITS
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      t_valid,
    input  logic [T_FRAC_BITS:0]      t,
    output logic                      w_valid,
    output logic [T_FRAC_BITS:0]      a,
    output logic [T_FRAC_BITS:0]      b,
    output logic [T_FRAC_BITS:0]      c,
    output logic signed [T_FRAC_BITS+2:0] w0,
    output logic signed [T_FRAC_BITS+2:0] w1,
    output logic signed [T_FRAC_BITS+2:0] w2,
    output logic signed [T_FRAC_BITS+2:0] w3
);
    import bzp_pkg::*;

    localparam int F  = T_FRAC_BITS;
    localparam int TW = F + 1;
    localparam int PW = 2 * F + 2;
    localparam int WW = F + 3;
    localparam logic [TW-1:0] ONE   = {1'b1, {F{1'b0}}};
    localparam logic [PW:0]   HALF  = (PW+1)'(1) << (F - 1);
    localparam logic [PW+1:0] HALF2 = (PW+2)'(1) << (F - 1);

    logic [BASIS_LAT-1:0] vld_reg;

    logic [TW-1:0] t1_reg, u1_reg, t1_next, u1_next;
    logic [PW-1:0] uu2_reg, ut2_reg, tt2_reg, uu2_next, ut2_next, tt2_next;
    logic [TW-1:0] t2_reg, u2_reg;
    logic [TW-1:0] a3_reg, b3_reg, c3_reg, t3_reg, u3_reg, a3_next, b3_next, c3_next;
    logic [PW-1:0] at4_reg, cu4_reg, ct4_reg, at4_next, cu4_next, ct4_next;
    logic [TW-1:0] a4_reg, b4_reg, c4_reg;
    logic [F+1:0]  w15_reg, w25_reg, w35_reg, w15_next, w25_next, w35_next;
    logic [TW-1:0] a5_reg, b5_reg, c5_reg;
    logic signed [WW-1:0] w06_reg, w16_reg, w26_reg, w36_reg, w06_next;
    logic [TW-1:0] a6_reg, b6_reg, c6_reg;

    always_comb
    begin
        logic [PW:0]   sa, sb, sc, s3;
        logic [PW+1:0] s1, s2;
        t1_next = (t > ONE) ? ONE : t;
        u1_next = ONE - t1_next;
        uu2_next = u1_reg * u1_reg;
        ut2_next = u1_reg * t1_reg;
        tt2_next = t1_reg * t1_reg;
        sa = {1'b0, uu2_reg} + HALF;
        sb = {1'b0, ut2_reg} + HALF;
        sc = {1'b0, tt2_reg} + HALF;
        a3_next = sa[F +: TW];
        b3_next = sb[F +: TW];
        c3_next = sc[F +: TW];
        at4_next = a3_reg * t3_reg;
        cu4_next = c3_reg * u3_reg;
        ct4_next = c3_reg * t3_reg;
        s1 = {2'b00, at4_reg} + {1'b0, at4_reg, 1'b0} + HALF2;
        s2 = {2'b00, cu4_reg} + {1'b0, cu4_reg, 1'b0} + HALF2;
        s3 = {1'b0, ct4_reg} + HALF;
        w15_next = s1[F +: F+2];
        w25_next = s2[F +: F+2];
        w35_next = s3[F +: F+2];
        w06_next = $signed({2'b00, ONE}) - $signed({1'b0, w15_reg})
                 - $signed({1'b0, w25_reg}) - $signed({1'b0, w35_reg});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[BASIS_LAT-2:0], t_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        t1_reg  <= t1_next;
        u1_reg  <= u1_next;
        uu2_reg <= uu2_next;
        ut2_reg <= ut2_next;
        tt2_reg <= tt2_next;
        t2_reg  <= t1_reg;
        u2_reg  <= u1_reg;
        a3_reg  <= a3_next;
        b3_reg  <= b3_next;
        c3_reg  <= c3_next;
        t3_reg  <= t2_reg;
        u3_reg  <= u2_reg;
        at4_reg <= at4_next;
        cu4_reg <= cu4_next;
        ct4_reg <= ct4_next;
        a4_reg  <= a3_reg;
        b4_reg  <= b3_reg;
        c4_reg  <= c3_reg;
        w15_reg <= w15_next;
        w25_reg <= w25_next;
        w35_reg <= w35_next;
        a5_reg  <= a4_reg;
        b5_reg  <= b4_reg;
        c5_reg  <= c4_reg;
        w06_reg <= w06_next;
        w16_reg <= $signed({1'b0, w15_reg});
        w26_reg <= $signed({1'b0, w25_reg});
        w36_reg <= $signed({1'b0, w35_reg});
        a6_reg  <= a5_reg;
        b6_reg  <= b5_reg;
        c6_reg  <= c5_reg;
    end

    assign w_valid = vld_reg[BASIS_LAT-1];
    assign a  = a6_reg;
    assign b  = b6_reg;
    assign c  = c6_reg;
    assign w0 = w06_reg;
    assign w1 = w16_reg;
    assign w2 = w26_reg;
    assign w3 = w36_reg;

endmodule

[hw/rtl/bzp_lane.sv]
// one coordinate lane: curve position and raw tangent component
`timescale 1ns / 1ps
module bzp_lane
#(
    parameter int COORD_WIDTH = bzp_pkg::DEF_COORD_WIDTH,
    parameter int T_FRAC_BITS = bzp_pkg::DEF_T_FRAC_BITS
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          w_valid,
    input  logic signed [COORD_WIDTH-1:0] p0,
    input  logic signed [COORD_WIDTH-1:0] p1,
    input  logic signed [COORD_WIDTH-1:0] p2,
    input  logic signed [COORD_WIDTH-1:0] p3,
    input  logic [T_FRAC_BITS:0]          a,
    input  logic [T_FRAC_BITS:0]          b,
    input  logic [T_FRAC_BITS:0]          c,
    input  logic signed [T_FRAC_BITS+2:0] w0,
    input  logic signed [T_FRAC_BITS+2:0] w1,
    input  logic signed [T_FRAC_BITS+2:0] w2,
    input  logic signed [T_FRAC_BITS+2:0] w3,
    output logic                          d_valid,
    output logic signed [COORD_WIDTH-1:0] pos,
    output logic signed [COORD_WIDTH+T_FRAC_BITS+6:0] d
);
    import bzp_pkg::*;

    localparam int CW = COORD_WIDTH;
    localparam int F  = T_FRAC_BITS;
    localparam int MW = CW + F + 3;
    localparam int DW = CW + F + 7;
    localparam logic signed [MW+1:0] HALF = (MW+2)'(1) <<< (F - 1);
    localparam logic signed [CW+4:0] PMAX = (CW+5)'((2 ** (CW - 1)) - 1);
    localparam logic signed [CW+4:0] PMIN = -PMAX - (CW+5)'(1);

    logic [LANE_LAT-1:0] vld_reg;

    logic signed [CW:0]   d10, d21, d32;
    logic signed [F+1:0]  as, bs, cs;
    logic signed [MW-1:0] m0_reg, m1_reg, m2_reg, m3_reg, q0_reg, q1_reg, q2_reg;
    logic signed [MW-1:0] m0_next, m1_next, m2_next, m3_next, q0_next, q1_next, q2_next;
    logic signed [MW:0]   s01_reg, s23_reg, s01_next, s23_next;
    logic signed [MW+1:0] e_reg, e_next, acc_reg, acc_next;
    logic signed [DW-1:0] d3_reg, d3_next, d4_reg;
    logic signed [CW-1:0] pos_reg, pos_next;

    always_comb
    begin
        logic signed [CW+4:0] shv;
        d10 = p1 - p0;
        d21 = p2 - p1;
        d32 = p3 - p2;
        as = $signed({1'b0, a});
        bs = $signed({1'b0, b});
        cs = $signed({1'b0, c});
        m0_next = p0 * w0;
        m1_next = p1 * w1;
        m2_next = p2 * w2;
        m3_next = p3 * w3;
        q0_next = d10 * as;
        q1_next = d21 * bs;
        q2_next = d32 * cs;
        s01_next = (MW+1)'(m0_reg) + (MW+1)'(m1_reg);
        s23_next = (MW+1)'(m2_reg) + (MW+1)'(m3_reg);
        e_next = (MW+2)'(q0_reg) + ((MW+2)'(q1_reg) <<< 1) + (MW+2)'(q2_reg);
        acc_next = (MW+2)'(s01_reg) + (MW+2)'(s23_reg) + HALF;
        d3_next = DW'(e_reg) + (DW'(e_reg) <<< 1);
        shv = $signed(acc_reg[MW+1:F]);
        if (shv > PMAX)
        begin
            pos_next = PMAX[CW-1:0];
        end
        else if (shv < PMIN)
        begin
            pos_next = PMIN[CW-1:0];
        end
        else
        begin
            pos_next = shv[CW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[LANE_LAT-2:0], w_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        m0_reg  <= m0_next;
        m1_reg  <= m1_next;
        m2_reg  <= m2_next;
        m3_reg  <= m3_next;
        q0_reg  <= q0_next;
        q1_reg  <= q1_next;
        q2_reg  <= q2_next;
        s01_reg <= s01_next;
        s23_reg <= s23_next;
        e_reg   <= e_next;
        acc_reg <= acc_next;
        d3_reg  <= d3_next;
        pos_reg <= pos_next;
        d4_reg  <= d3_reg;
    end

    assign d_valid = vld_reg[LANE_LAT-1];
    assign pos     = pos_reg;
    assign d       = d4_reg;

endmodule

[hw/rtl/bzp_unit.sv]
// tangent normalisation: leading-zero shift, squared length, root and divide
`timescale 1ns / 1ps
module bzp_unit
#(
    parameter int D_WIDTH = bzp_pkg::DEF_D_WIDTH
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              d_valid,
    input  logic signed [D_WIDTH-1:0]         dx,
    input  logic signed [D_WIDTH-1:0]         dy,
    input  logic signed [D_WIDTH-1:0]         dz,
    output bzp_pkg::ctl_t                     ctl,
    output logic signed [bzp_pkg::UN_W-1:0]   ux,
    output logic signed [bzp_pkg::UN_W-1:0]   uy,
    output logic signed [bzp_pkg::UN_W-1:0]   uz
);
    import bzp_pkg::*;

    localparam int NS   = NORM_STEPS;
    localparam int DSH  = MAG_W - UNIT_BITS;
    localparam int SR_W = SQ_W + 1;
    localparam logic signed [MAG_W+1:0] RND = (MAG_W+2)'(1) <<< (DSH - 1);

    logic signed [D_WIDTH-1:0] d_in [0:2];

    logic signed [MAG_W:0] nv_reg  [0:NS][0:2];
    logic signed [MAG_W:0] nv_next [0:NS][0:2];
    logic [MAG_W-1:0]      nm_reg  [0:NS];
    logic [MAG_W-1:0]      nm_next [0:NS];

    logic signed [DN_W-1:0] dn_reg [0:2];
    logic signed [DN_W-1:0] dn_next [0:2];
    logic                   z7_reg, z7_next;
    logic [SQ_W-1:0]        sq_reg [0:2];
    logic [SQ_W-1:0]        sq_next [0:2];
    logic signed [DN_W-1:0] dn8_reg [0:2];
    logic                   z8_reg;

    logic [SQ_W-1:0]        sv_reg  [0:ROOT_W];
    logic [SQ_W-1:0]        sv_next [0:ROOT_W];
    logic [SR_W-1:0]        sr_reg  [0:ROOT_W];
    logic [SR_W-1:0]        sr_next [0:ROOT_W];
    logic signed [DN_W-1:0] sd_reg  [0:ROOT_W][0:2];
    logic signed [DN_W-1:0] sd_next [0:ROOT_W][0:2];
    logic [ROOT_W:0]        sz_reg, sz_next;

    logic [REM_W-1:0]  dr_reg   [0:Q_W][0:2];
    logic [REM_W-1:0]  dr_next  [0:Q_W][0:2];
    logic [Q_W-1:0]    dq_reg   [0:Q_W][0:2];
    logic [Q_W-1:0]    dq_next  [0:Q_W][0:2];
    logic [2:0]        dsg_reg  [0:Q_W];
    logic [2:0]        dsg_next [0:Q_W];
    logic [ROOT_W-1:0] dl_reg   [0:Q_W];
    logic [ROOT_W-1:0] dl_next  [0:Q_W];
    logic [Q_W:0]      dz_reg, dz_next;

    logic signed [UN_W-1:0] un_reg [0:2];
    logic signed [UN_W-1:0] un_next [0:2];
    logic                   fz_reg, fz_next;
    logic [UNIT_LAT-1:0]    uv_reg;

    assign d_in[0] = dx;
    assign d_in[1] = dy;
    assign d_in[2] = dz;

    // sign extend, merge magnitudes, then shift left until the top bit is set
    always_comb
    begin
        logic signed [MAG_W:0] ext;
        logic [MAG_W:0]        absv;
        logic [MAG_W-1:0]      acc;
        logic [MAG_W-1:0]      top;
        int                    sh;
        acc = '0;
        for (int i = 0; i < 3; i++)
        begin
            ext = (MAG_W+1)'(d_in[i]);
            absv = ext[MAG_W] ? -ext : ext;
            nv_next[0][i] = ext;
            acc = acc | absv[MAG_W-1:0];
        end
        nm_next[0] = acc;
        for (int s = 1; s <= NS; s++)
        begin
            sh = 1 << (NS - s);
            top = nm_reg[s-1] >> (MAG_W - sh);
            if (top == '0)
            begin
                nm_next[s] = nm_reg[s-1] << sh;
                for (int i = 0; i < 3; i++)
                begin
                    nv_next[s][i] = nv_reg[s-1][i] <<< sh;
                end
            end
            else
            begin
                nm_next[s] = nm_reg[s-1];
                for (int i = 0; i < 3; i++)
                begin
                    nv_next[s][i] = nv_reg[s-1][i];
                end
            end
        end
    end

    // round to thirty bits, square, sum, and the root stages
    always_comb
    begin
        logic signed [MAG_W+1:0]  rv;
        logic signed [2*DN_W-1:0] p;
        logic [SR_W-1:0]          bitv;
        logic [SR_W-1:0]          trial;
        for (int i = 0; i < 3; i++)
        begin
            rv = (MAG_W+2)'(nv_reg[NS][i]) + RND;
            dn_next[i] = $signed(rv[MAG_W+1:DSH]);
            p = dn_reg[i] * dn_reg[i];
            sq_next[i] = p[SQ_W-1:0];
            sd_next[0][i] = dn8_reg[i];
        end
        z7_next = (nm_reg[NS] == '0);
        sv_next[0] = sq_reg[0] + sq_reg[1] + sq_reg[2];
        sr_next[0] = '0;
        sz_next[0] = z8_reg;
        for (int s = 1; s <= ROOT_W; s++)
        begin
            bitv = SR_W'(1) << (2 * (ROOT_W - s));
            trial = sr_reg[s-1] + bitv;
            if ({1'b0, sv_reg[s-1]} >= trial)
            begin
                sv_next[s] = sv_reg[s-1] - trial[SQ_W-1:0];
                sr_next[s] = (sr_reg[s-1] >> 1) + bitv;
            end
            else
            begin
                sv_next[s] = sv_reg[s-1];
                sr_next[s] = sr_reg[s-1] >> 1;
            end
            for (int i = 0; i < 3; i++)
            begin
                sd_next[s][i] = sd_reg[s-1][i];
            end
            sz_next[s] = sz_reg[s-1];
        end
    end

    // rounded divide of each component by the length, one quotient bit a stage
    always_comb
    begin
        logic [ROOT_W-1:0] len;
        logic [DN_W-1:0]   mag;
        logic [REM_W-1:0]  cmp;
        int                k;
        len = sr_reg[ROOT_W][ROOT_W-1:0];
        for (int i = 0; i < 3; i++)
        begin
            mag = sd_reg[ROOT_W][i][DN_W-1] ? DN_W'(-sd_reg[ROOT_W][i])
                                            : DN_W'(sd_reg[ROOT_W][i]);
            dr_next[0][i] = (REM_W'(mag) << NRM_FRAC) + REM_W'(len >> 1);
            dq_next[0][i] = '0;
            dsg_next[0][i] = sd_reg[ROOT_W][i][DN_W-1];
        end
        dl_next[0] = len;
        dz_next[0] = sz_reg[ROOT_W];
        for (int s = 1; s <= Q_W; s++)
        begin
            k = Q_W - s;
            cmp = REM_W'(dl_reg[s-1]) << k;
            for (int i = 0; i < 3; i++)
            begin
                if (dr_reg[s-1][i] >= cmp)
                begin
                    dr_next[s][i] = dr_reg[s-1][i] - cmp;
                    dq_next[s][i] = dq_reg[s-1][i] | (Q_W'(1) << k);
                end
                else
                begin
                    dr_next[s][i] = dr_reg[s-1][i];
                    dq_next[s][i] = dq_reg[s-1][i];
                end
            end
            dsg_next[s] = dsg_reg[s-1];
            dl_next[s] = dl_reg[s-1];
            dz_next[s] = dz_reg[s-1];
        end
        for (int i = 0; i < 3; i++)
        begin
            un_next[i] = dsg_reg[Q_W][i] ? $signed(UN_W'(-dq_reg[Q_W][i]))
                                         : $signed(UN_W'(dq_reg[Q_W][i]));
        end
        fz_next = dz_reg[Q_W];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            uv_reg <= '0;
        end
        else
        begin
            uv_reg <= {uv_reg[UNIT_LAT-2:0], d_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        nv_reg  <= nv_next;
        nm_reg  <= nm_next;
        dn_reg  <= dn_next;
        z7_reg  <= z7_next;
        sq_reg  <= sq_next;
        dn8_reg <= dn_reg;
        z8_reg  <= z7_reg;
        sv_reg  <= sv_next;
        sr_reg  <= sr_next;
        sd_reg  <= sd_next;
        sz_reg  <= sz_next;
        dr_reg  <= dr_next;
        dq_reg  <= dq_next;
        dsg_reg <= dsg_next;
        dl_reg  <= dl_next;
        dz_reg  <= dz_next;
        un_reg  <= un_next;
        fz_reg  <= fz_next;
    end

    assign ctl.valid = uv_reg[UNIT_LAT-1];
    assign ctl.zero  = fz_reg;
    assign ux = un_reg[0];
    assign uy = un_reg[1];
    assign uz = un_reg[2];

endmodule

[hw/rtl/cubic_bezier_point_and_perp.sv]
// top level: configuration registers, lanes, normalisation and cross product
// done rises once a request has passed the basis, lane, normalisation and cross product registers
// throughput: one request per cycle, busy is never high and the result side cannot stall
// the rate is set by the fully pipelined root (31 stages) and divider (16 stages)
// reset clears the configuration registers and all pipeline valid bits
`timescale 1ns / 1ps
module cubic_bezier_point_and_perp
#(
    parameter int COORD_WIDTH = bzp_pkg::DEF_COORD_WIDTH,
    parameter int T_FRAC_BITS = bzp_pkg::DEF_T_FRAC_BITS
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [T_FRAC_BITS:0]              t_param,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [bzp_pkg::IDX_W-1:0]         cfg_index,
    input  logic [bzp_pkg::CFG_W-1:0]         cfg_data,
    output logic                              done,
    output logic signed [COORD_WIDTH-1:0]     pos_x,
    output logic signed [COORD_WIDTH-1:0]     pos_y,
    output logic signed [COORD_WIDTH-1:0]     pos_z,
    output logic signed [bzp_pkg::NRM_W-1:0]  perp_x,
    output logic signed [bzp_pkg::NRM_W-1:0]  perp_y,
    output logic signed [bzp_pkg::NRM_W-1:0]  perp_z,
    output logic                              zero_tangent
);
    import bzp_pkg::*;

    localparam int CW  = COORD_WIDTH;
    localparam int F   = T_FRAC_BITS;
    localparam int DW  = CW + F + 7;
    localparam int PDW = CFG_W + 3 * CW;
    localparam int XW  = 2 * NRM_W + 1;
    localparam logic signed [XW-1:0] XHALF = XW'(1) <<< (NRM_FRAC - 1);
    localparam logic signed [XW-NRM_FRAC-1:0] XMAX = (XW-NRM_FRAC)'((2 ** (NRM_W - 1)) - 1);
    localparam logic signed [XW-NRM_FRAC-1:0] XMIN = -XMAX - (XW-NRM_FRAC)'(1);

    function automatic logic signed [NRM_W-1:0] sat_perp(input logic signed [XW-1:0] v);
        logic signed [XW-1:0]          r;
        logic signed [XW-NRM_FRAC-1:0] q;
        r = v + XHALF;
        q = $signed(r[XW-1:NRM_FRAC]);
        if (q > XMAX)
        begin
            return XMAX[NRM_W-1:0];
        end
        else if (q < XMIN)
        begin
            return XMIN[NRM_W-1:0];
        end
        return q[NRM_W-1:0];
    endfunction

    logic [CFG_W-1:0] sp_reg, ep_reg, sc_reg, ec_reg, sn_reg;
    logic [PDW-1:0]   sp_pad, ep_pad, sc_pad, ec_pad;

    logic             w_valid;
    logic [F:0]       ca, cb, cc;
    logic signed [F+2:0] cw0, cw1, cw2, cw3;

    logic [2:0]             lv;
    logic signed [CW-1:0]   pos_l [0:2];
    logic signed [DW-1:0]   d_l [0:2];

    ctl_t                   uctl;
    logic signed [UN_W-1:0] ux, uy, uz;
    logic signed [NRM_W-1:0] nrm [0:2];

    logic signed [CW-1:0]    pd_reg [0:UNIT_LAT-1][0:2];
    logic signed [CW-1:0]    px1_reg [0:2];
    logic signed [2*NRM_W-1:0] pr_reg [0:5];
    logic                    x1v_reg, x1z_reg;
    logic                    done_reg, zt_reg;
    logic signed [CW-1:0]    pos_reg [0:2];
    logic signed [NRM_W-1:0] perp_reg [0:2];

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sp_reg <= '0;
            ep_reg <= '0;
            sc_reg <= '0;
            ec_reg <= '0;
            sn_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_START_POINT:    sp_reg <= cfg_data;
                REG_END_POINT:      ep_reg <= cfg_data;
                REG_START_CONTROL:  sc_reg <= cfg_data;
                REG_END_CONTROL:    ec_reg <= cfg_data;
                REG_SURFACE_NORMAL: sn_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    assign sp_pad = {{(3*CW){1'b0}}, sp_reg};
    assign ep_pad = {{(3*CW){1'b0}}, ep_reg};
    assign sc_pad = {{(3*CW){1'b0}}, sc_reg};
    assign ec_pad = {{(3*CW){1'b0}}, ec_reg};

    bzp_basis #(.T_FRAC_BITS(T_FRAC_BITS)) u_basis
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .t_valid (start && !busy),
        .t       (t_param),
        .w_valid (w_valid),
        .a       (ca),
        .b       (cb),
        .c       (cc),
        .w0      (cw0),
        .w1      (cw1),
        .w2      (cw2),
        .w3      (cw3)
    );

    for (genvar i = 0; i < 3; i++)
    begin : g_lane
        bzp_lane #(.COORD_WIDTH(COORD_WIDTH), .T_FRAC_BITS(T_FRAC_BITS)) u_lane
        (
            .clk     (clk),
            .rst_n   (rst_n),
            .w_valid (w_valid),
            .p0      ($signed(sp_pad[i*CW +: CW])),
            .p1      ($signed(sc_pad[i*CW +: CW])),
            .p2      ($signed(ec_pad[i*CW +: CW])),
            .p3      ($signed(ep_pad[i*CW +: CW])),
            .a       (ca),
            .b       (cb),
            .c       (cc),
            .w0      (cw0),
            .w1      (cw1),
            .w2      (cw2),
            .w3      (cw3),
            .d_valid (lv[i]),
            .pos     (pos_l[i]),
            .d       (d_l[i])
        );
        assign nrm[i] = $signed(sn_reg[i*NRM_W +: NRM_W]);
    end

    bzp_unit #(.D_WIDTH(DW)) u_unit
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .d_valid (&lv),
        .dx      (d_l[0]),
        .dy      (d_l[1]),
        .dz      (d_l[2]),
        .ctl     (uctl),
        .ux      (ux),
        .uy      (uy),
        .uz      (uz)
    );

    // position waits alongside the normalisation pipeline
    always_ff @(posedge clk)
    begin
        pd_reg[0] <= pos_l;
        for (int k = 1; k < UNIT_LAT; k++)
        begin
            pd_reg[k] <= pd_reg[k-1];
        end
        px1_reg   <= pd_reg[UNIT_LAT-1];
        x1z_reg   <= uctl.zero;
        pr_reg[0] <= nrm[1] * uz;
        pr_reg[1] <= nrm[2] * uy;
        pr_reg[2] <= nrm[2] * ux;
        pr_reg[3] <= nrm[0] * uz;
        pr_reg[4] <= nrm[0] * uy;
        pr_reg[5] <= nrm[1] * ux;
        pos_reg   <= px1_reg;
        zt_reg    <= x1z_reg;
        if (x1z_reg)
        begin
            perp_reg[0] <= '0;
            perp_reg[1] <= '0;
            perp_reg[2] <= '0;
        end
        else
        begin
            perp_reg[0] <= sat_perp(XW'(pr_reg[0]) - XW'(pr_reg[1]));
            perp_reg[1] <= sat_perp(XW'(pr_reg[2]) - XW'(pr_reg[3]));
            perp_reg[2] <= sat_perp(XW'(pr_reg[4]) - XW'(pr_reg[5]));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x1v_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            x1v_reg  <= uctl.valid;
            done_reg <= x1v_reg;
        end
    end

    assign done         = done_reg;
    assign pos_x        = pos_reg[0];
    assign pos_y        = pos_reg[1];
    assign pos_z        = pos_reg[2];
    assign perp_x       = perp_reg[0];
    assign perp_y       = perp_reg[1];
    assign perp_z       = perp_reg[2];
    assign zero_tangent = zt_reg;

endmodule

[tb/sv/tb_cubic_bezier_point_and_perp.sv]
// testbench for the cubic bezier point and perpendicular block, with a self-checking scoreboard
`timescale 1ns / 1ps
module tb_cubic_bezier_point_and_perp;

    import bzp_pkg::*;

    localparam int CW        = DEF_COORD_WIDTH;
    localparam int TF        = DEF_T_FRAC_BITS;
    localparam int NUM_REGS  = 5;
    localparam int LATENCY   = 70;
    localparam int MAX_CYCLE = 400000;

    typedef struct {
        logic signed [CW-1:0]    pos [3];
        logic signed [NRM_W-1:0] perp [3];
        logic                    zero;
    } curve_sample_t;

    class bezier_scoreboard;
        logic [CFG_W-1:0] regs [NUM_REGS];
        curve_sample_t    expected_samples [$];
        int               zero_count;
        int               clamp_count;

        function new();
            foreach (regs[i])
                regs[i] = '0;
        endfunction

        function void set_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] val);
            if (idx < NUM_REGS)
                regs[idx] = val;
        endfunction

        static function longint rnd_shr(longint v, int sh);
            return (v + (longint'(1) << (sh - 1))) >>> sh;
        endfunction

        static function longint clip(longint v, int w);
            longint hi;
            longint lo;
            hi = (longint'(1) << (w - 1)) - 1;
            lo = -hi - 1;
            return v > hi ? hi : (v < lo ? lo : v);
        endfunction

        static function longint unsigned int_sqrt(longint unsigned v);
            longint unsigned r;
            longint unsigned b;
            r = 0;
            b = longint'(1) << 62;
            while (b > v)
                b >>= 2;
            while (b != 0)
            begin
                if (v >= r + b)
                begin
                    v -= r + b;
                    r = (r >> 1) + b;
                end
                else
                    r >>= 1;
                b >>= 2;
            end
            return r;
        endfunction

        static function longint lane_of(logic [CFG_W-1:0] r, int i);
            logic signed [15:0] x;
            x = r[16*i +: 16];
            return longint'(x);
        endfunction

        function void note_request(logic [TF:0] t_in);
            curve_sample_t    res;
            longint           s, t, u, a, b, c, w0, w1, w2, w3, len, acc, m;
            longint           p0, p1, p2, p3;
            longint           d [3];
            longint           n [3];
            longint           un [3];
            longint           cr [3];
            longint unsigned  mag, sum;
            int               bl;
            s = longint'(1) << TF;
            t = longint'(t_in);
            if (t > s)
            begin
                t = s;
                clamp_count++;
            end
            u  = s - t;
            a  = rnd_shr(u * u, TF);
            b  = rnd_shr(u * t, TF);
            c  = rnd_shr(t * t, TF);
            w1 = rnd_shr(3 * a * t, TF);
            w2 = rnd_shr(3 * c * u, TF);
            w3 = rnd_shr(c * t, TF);
            w0 = s - w1 - w2 - w3;
            mag = 0;
            for (int i = 0; i < 3; i++)
            begin
                p0 = lane_of(regs[REG_START_POINT], i);
                p1 = lane_of(regs[REG_START_CONTROL], i);
                p2 = lane_of(regs[REG_END_CONTROL], i);
                p3 = lane_of(regs[REG_END_POINT], i);
                acc = p0 * w0 + p1 * w1 + p2 * w2 + p3 * w3;
                res.pos[i] = CW'(clip(rnd_shr(acc, TF), CW));
                d[i] = 3 * a * (p1 - p0) + 6 * b * (p2 - p1) + 3 * c * (p3 - p2);
                n[i] = lane_of(regs[REG_SURFACE_NORMAL], i);
                m = d[i] < 0 ? -d[i] : d[i];
                if (longint'(m) > longint'(mag))
                    mag = m;
            end
            if (mag == 0)
            begin
                foreach (res.perp[i])
                    res.perp[i] = '0;
                res.zero = 1'b1;
                zero_count++;
            end
            else
            begin
                bl = $clog2(mag + 1);
                sum = 0;
                for (int i = 0; i < 3; i++)
                begin
                    if (bl > UNIT_BITS)
                        d[i] = rnd_shr(d[i], bl - UNIT_BITS);
                    else
                        d[i] = d[i] << (UNIT_BITS - bl);
                    sum += longint'(d[i] * d[i]);
                end
                len = longint'(int_sqrt(sum));
                if (len < 1)
                    len = 1;
                for (int i = 0; i < 3; i++)
                begin
                    m = d[i] < 0 ? -d[i] : d[i];
                    m = (m * 16384 + len / 2) / len;
                    un[i] = d[i] < 0 ? -m : m;
                end
                cr[0] = n[1] * un[2] - n[2] * un[1];
                cr[1] = n[2] * un[0] - n[0] * un[2];
                cr[2] = n[0] * un[1] - n[1] * un[0];
                for (int i = 0; i < 3; i++)
                    res.perp[i] = NRM_W'(clip(rnd_shr(cr[i], NRM_FRAC), NRM_W));
                res.zero = 1'b0;
            end
            expected_samples.push_back(res);
        endfunction

        function string check_result(curve_sample_t got);
            curve_sample_t exp_s;
            string         msg;
            if (expected_samples.size() == 0)
                return "result with no request outstanding";
            exp_s = expected_samples.pop_front();
            msg = "";
            for (int i = 0; i < 3; i++)
            begin
                if (got.pos[i] !== exp_s.pos[i])
                    msg = {msg, $sformatf(" pos[%0d] %0d/%0d", i, got.pos[i], exp_s.pos[i])};
                if (got.perp[i] !== exp_s.perp[i])
                    msg = {msg, $sformatf(" perp[%0d] %0d/%0d", i, got.perp[i], exp_s.perp[i])};
            end
            if (got.zero !== exp_s.zero)
                msg = {msg, $sformatf(" zero_tangent %b/%b", got.zero, exp_s.zero)};
            return msg;
        endfunction

        function int pending();
            return expected_samples.size();
        endfunction
    endclass

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    start = 1'b0;
    logic                    busy;
    logic [TF:0]             t_param = '0;
    logic                    cfg_valid = 1'b0;
    logic                    cfg_ready;
    logic [IDX_W-1:0]        cfg_index = '0;
    logic [CFG_W-1:0]        cfg_data = '0;
    logic                    done;
    logic signed [CW-1:0]    pos_x, pos_y, pos_z;
    logic signed [NRM_W-1:0] perp_x, perp_y, perp_z;
    logic                    zero_tangent;

    bezier_scoreboard sb = new();
    int  mismatch_count = 0;
    int  request_count = 0;
    int  result_count = 0;
    int  cycle_count = 0;
    int  phase_count = 0;
    bit  no_idle = 1'b0;

    cubic_bezier_point_and_perp u_top
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .t_param      (t_param),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .done         (done),
        .pos_x        (pos_x),
        .pos_y        (pos_y),
        .pos_z        (pos_z),
        .perp_x       (perp_x),
        .perp_y       (perp_y),
        .perp_z       (perp_z),
        .zero_tangent (zero_tangent)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    task automatic report(string msg);
        mismatch_count++;
        $display("MISMATCH at cycle %0d:%s", cycle_count, msg);
    endtask

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > MAX_CYCLE)
        begin
            $display("timeout with %0d results outstanding", sb.pending());
            $display("Mismatches found");
            $finish;
        end
    end

    // requests accepted and results returned
    always @(posedge clk)
    begin
        curve_sample_t got;
        string         msg;
        if (rst_n && start && !busy)
        begin
            sb.note_request(t_param);
            request_count++;
        end
        if (rst_n && done)
        begin
            got.pos[0]  = pos_x;
            got.pos[1]  = pos_y;
            got.pos[2]  = pos_z;
            got.perp[0] = perp_x;
            got.perp[1] = perp_y;
            got.perp[2] = perp_z;
            got.zero    = zero_tangent;
            msg = sb.check_result(got);
            result_count++;
            if (msg != "")
                report(msg);
        end
    end

    task automatic write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(negedge clk);
        while (!cfg_ready);
        @(posedge clk);
        sb.set_reg(idx, val);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_point(logic [TF:0] t);
        if (!no_idle && $urandom_range(99) < 23)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 4))
                @(posedge clk);
        end
        start   <= 1'b1;
        t_param <= t;
        do
            @(negedge clk);
        while (busy);
        @(posedge clk);
    endtask

    task automatic drain();
        start <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (LATENCY + 10)
            @(posedge clk);
    endtask

    function automatic logic [15:0] rand_coord(int style);
        case (style)
            0: return 16'($urandom);
            1: return 16'($urandom_range(0, 2047) - 1024);
            2: return $urandom_range(1) ? 16'h7fff : 16'h8000;
            default: return 16'($urandom_range(0, 127) - 64);
        endcase
    endfunction

    function automatic logic [CFG_W-1:0] rand_triple(int style);
        return {rand_coord(style), rand_coord(style), rand_coord(style)};
    endfunction

    function automatic logic [CFG_W-1:0] rand_normal();
        case ($urandom_range(3))
            0: return {16'($urandom), 16'($urandom), 16'($urandom)};
            1: return {16'h4000, 16'h0000, 16'h0000};
            2: return {16'h8000, 16'h8000, 16'h7fff};
            default: return {16'($urandom_range(0, 32767) - 16384),
                             16'($urandom_range(0, 32767) - 16384),
                             16'($urandom_range(0, 32767) - 16384)};
        endcase
    endfunction

    task automatic load_curve(logic [CFG_W-1:0] p0, logic [CFG_W-1:0] p1,
                              logic [CFG_W-1:0] p2, logic [CFG_W-1:0] p3,
                              logic [CFG_W-1:0] nrm);
        write_reg(REG_START_POINT, p0);
        write_reg(REG_START_CONTROL, p1);
        write_reg(REG_END_CONTROL, p2);
        write_reg(REG_END_POINT, p3);
        write_reg(REG_SURFACE_NORMAL, nrm);
        phase_count++;
    endtask

    function automatic logic [TF:0] rand_t();
        int r;
        r = $urandom_range(99);
        if (r < 75)
            return 16'($urandom_range(0, 32768));
        else if (r < 85)
            return $urandom_range(1) ? 16'd0 : 16'd32768;
        else
            return 16'($urandom);
    endfunction

    initial
    begin
        int style;
        repeat (7)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset state: every point at origin so the tangent is zero
        send_point(16'd0);
        send_point(16'd32768);
        send_point(16'hffff);
        drain();

        // directed: straight line, extremes of t
        load_curve(48'h0000_0000_0000, 48'h0000_0000_0100, 48'h0000_0000_0200,
                   48'h0000_0000_0300, 48'h4000_0000_0000);
        send_point(16'd0);
        send_point(16'd1);
        send_point(16'd16384);
        send_point(16'd32767);
        send_point(16'd32768);
        send_point(16'd32769);
        send_point(16'hffff);
        send_point(16'h5555);
        send_point(16'haaaa);
        drain();
        // extremes of every coordinate, cusp at the start when p1 equals p0
        load_curve(48'h8000_8000_8000, 48'h8000_8000_8000, 48'h7fff_7fff_7fff,
                   48'h7fff_7fff_7fff, 48'h7fff_8000_7fff);
        write_reg(3'd5, 48'hffff_ffff_ffff);
        write_reg(3'd7, 48'h1234_5678_9abc);
        send_point(16'd0);
        send_point(16'd8192);
        send_point(16'd32768);
        send_point(16'd24576);
        drain();
        // degenerate curve: all points equal
        load_curve(48'h1234_8765_7fff, 48'h1234_8765_7fff, 48'h1234_8765_7fff,
                   48'h1234_8765_7fff, 48'h8000_8000_8000);
        write_reg(3'd6, 48'h0);
        send_point(16'd0);
        send_point(16'd12345);
        send_point(16'd32768);
        drain();

        // random curves, with one unbroken stretch and one full pause
        for (int ph = 0; ph < 8; ph++)
        begin
            style = ph % 4;
            load_curve(rand_triple(style), rand_triple(style), rand_triple(style),
                       rand_triple(style), rand_normal());
            if ($urandom_range(3) == 0)
                write_reg(3'($urandom_range(5, 7)), {16'($urandom), 32'($urandom)});
            no_idle = (ph == 3);
            for (int k = 0; k < 180; k++)
            begin
                send_point(rand_t());
                if (ph == 5 && k == 90)
                begin
                    start <= 1'b0;
                    while (sb.pending() != 0)
                        @(posedge clk);
                end
            end
            no_idle = 1'b0;
            drain();
        end

        $display("%0d requests over %0d curve settings, %0d results checked",
                 request_count, phase_count, result_count);
        $display("%0d zero-tangent results, %0d requests with t clamped to one",
                 sb.zero_count, sb.clamp_count);
        if (mismatch_count == 0 && sb.pending() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
